/* rtl/wowe_pkg.sv */
package wowe_pkg;

    typedef struct packed {
        logic       kind;
        logic [3:0] task_id;
        logic [3:0] object_id;
        logic       wait_all_mode;
        logic [7:0] wake_count;
        logic       wake_all;
    } wowe_in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] woken_task;
        logic       status;
        logic [7:0] remaining_count;
        logic       last;
    } wowe_out_t;

    localparam logic       KIND_ADD  = 1'b0;
    localparam logic       KIND_WAKE = 1'b1;
    localparam logic [1:0] RK_ADD_DONE  = 2'd0;
    localparam logic [1:0] RK_WOKEN     = 2'd1;
    localparam logic [1:0] RK_WAKE_DONE = 2'd2;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIND_FREE,
        OP_ADD_READ,
        OP_ADD_LINK,
        OP_ADD_FIX,
        OP_WAKE_PICK,
        OP_UNLINK,
        OP_TASK_CHECK,
        OP_EMIT_ADD,
        OP_EMIT_FULL,
        OP_EMIT_WOKEN,
        OP_EMIT_DONE
    } wowe_op_t;

    typedef struct packed {
        wowe_op_t op;
    } wowe_cmd_t;

    typedef struct packed {
        logic find_done;
        logic add_bad;
        logic pool_full;
        logic wake_more;
        logic task_wake;
        logic task_more;
    } wowe_stat_t;

endpackage

/* rtl/wait_object_wake_engine_core.sv */
// Wait-object wake engine. Assert start with a transaction on in_item while
// busy is low; busy then stays high until the final result has been issued.
// Results appear on result for one cycle each, flagged by result_valid, and
// the receiver cannot stall them; the one with last set ends the transaction.
// Node links sit in RAMs with registered reads, so every step that follows a
// link waits for a RAM read. An add finds its node by a linear free search
// from index zero; a refused add on a full pool scans the whole pool. A wake
// removes nodes from the object one at a time; for each woken task it then
// frees that task's further nodes.
module wait_object_wake_engine_core
    import wowe_pkg::*;
#(
    parameter int TASK_COUNT   = 16,
    parameter int OBJECT_COUNT = 16,
    parameter int NODE_COUNT   = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  wowe_in_t  in_item,
    output wowe_out_t result,
    output logic      result_valid
);
    wowe_cmd_t  cmd;
    wowe_stat_t stat;
    logic       kind_reg;

    // hold the transaction kind for dispatch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_ADD;
        else if (start && !busy)
            kind_reg <= in_item.kind;
    end

    wowe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind_reg),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    wowe_dpath #(
        .TASK_COUNT   (TASK_COUNT),
        .OBJECT_COUNT (OBJECT_COUNT),
        .NODE_COUNT   (NODE_COUNT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

    a_last_drops_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy) else $error("busy after last");
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !result_valid) else $error("stray result");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.result_kind != 2'd3)) else $error("bad result kind");
endmodule

/* rtl/wowe_dpath.sv */
module wowe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

module wowe_dpath
    import wowe_pkg::*;
#(
    parameter int TASK_COUNT   = 16,
    parameter int OBJECT_COUNT = 16,
    parameter int NODE_COUNT   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  wowe_in_t   in_item,
    input  wowe_cmd_t  cmd,
    output wowe_stat_t stat,
    output wowe_out_t  result,
    output logic       result_valid
);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NW1 = NW + 1;
    localparam int TW  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int OW  = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;

    logic [NODE_COUNT-1:0] nvalid_reg;
    logic [NW-1:0] ohead_reg [OBJECT_COUNT];
    logic [NW:0]   owait_reg [OBJECT_COUNT];
    logic [NW-1:0] thead_reg [TASK_COUNT];
    logic [NW:0]   twait_reg [TASK_COUNT];
    logic [TASK_COUNT-1:0] tall_reg;

    wowe_in_t item_reg;
    logic [NW-1:0] scan_reg, node_reg, otail_reg, ttail_reg;
    logic [8:0] count_reg;
    logic [3:0] task_reg;

    // node store: task, object and ring links live in RAMs with registered reads
    logic [NW-1:0] raddr_o, raddr_t;
    logic [3:0]    ntask_rd, nobj_rd;
    logic [NW-1:0] onext_rd, oprev_rd, tnext_rd, tprev_rd;
    logic          link_we;
    logic          onext_we, oprev_we, tnext_we, tprev_we;
    logic [NW-1:0] onext_wa, oprev_wa, tnext_wa, tprev_wa;
    logic [NW-1:0] onext_wd, oprev_wd, tnext_wd, tprev_wd;
    logic          emit;
    logic          o_had, t_had;

    logic [3:0] t4, o4;
    logic [TW-1:0] ti, wt, ut;
    logic [OW-1:0] oi, uo;
    assign t4 = item_reg.task_id;
    assign o4 = item_reg.object_id;
    assign ti = TW'(t4);
    assign oi = OW'(o4);
    assign wt = TW'(task_reg);
    assign ut = TW'(ntask_rd);
    assign uo = OW'(nobj_rd);

    // at the fix step the counts already include the new node
    assign o_had = owait_reg[oi] != NW1'(1);
    assign t_had = twait_reg[ti] != NW1'(1);
    assign link_we = cmd.op == OP_ADD_LINK;

    always_comb
    begin
        stat.find_done = !nvalid_reg[scan_reg] || (32'(scan_reg) == NODE_COUNT - 1);
        stat.pool_full = nvalid_reg[scan_reg];
        stat.add_bad   = (32'(t4) >= TASK_COUNT) || (32'(o4) >= OBJECT_COUNT);
        stat.wake_more = (32'(o4) < OBJECT_COUNT) && (owait_reg[oi] != '0)
                         && (item_reg.wake_all || count_reg != '0);
        stat.task_wake = (twait_reg[wt] == '0) || !tall_reg[wt];
        stat.task_more = twait_reg[wt] != '0;
    end

    // read ports: object side feeds nobj/onext/oprev, task side the rest
    always_comb
    begin
        raddr_o = node_reg;
        raddr_t = node_reg;
        case (cmd.op)
            OP_WAKE_PICK:
            begin
                raddr_o = ohead_reg[oi];
                raddr_t = ohead_reg[oi];
            end
            OP_TASK_CHECK:
            begin
                raddr_o = thead_reg[wt];
                raddr_t = thead_reg[wt];
            end
            OP_ADD_READ:
            begin
                raddr_o = ohead_reg[oi];
                raddr_t = thead_reg[ti];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        onext_we = 1'b0;
        oprev_we = 1'b0;
        tnext_we = 1'b0;
        tprev_we = 1'b0;
        onext_wa = scan_reg;
        oprev_wa = scan_reg;
        tnext_wa = scan_reg;
        tprev_wa = scan_reg;
        onext_wd = scan_reg;
        oprev_wd = scan_reg;
        tnext_wd = scan_reg;
        tprev_wd = scan_reg;
        case (cmd.op)
            OP_ADD_LINK:
            begin
                // new node: self ring when the list is empty, else head and tail
                onext_we = 1'b1;
                oprev_we = 1'b1;
                tnext_we = 1'b1;
                tprev_we = 1'b1;
                if (owait_reg[oi] != '0)
                begin
                    onext_wd = ohead_reg[oi];
                    oprev_wd = oprev_rd;
                end
                if (twait_reg[ti] != '0)
                begin
                    tnext_wd = thead_reg[ti];
                    tprev_wd = tprev_rd;
                end
            end
            OP_ADD_FIX:
            begin
                // splice the new node between old tail and head
                onext_we = o_had;
                oprev_we = o_had;
                tnext_we = t_had;
                tprev_we = t_had;
                onext_wa = otail_reg;
                oprev_wa = ohead_reg[oi];
                tnext_wa = ttail_reg;
                tprev_wa = thead_reg[ti];
            end
            OP_UNLINK:
            begin
                onext_we = 1'b1;
                oprev_we = 1'b1;
                tnext_we = 1'b1;
                tprev_we = 1'b1;
                oprev_wa = onext_rd;
                oprev_wd = oprev_rd;
                onext_wa = oprev_rd;
                onext_wd = onext_rd;
                tprev_wa = tnext_rd;
                tprev_wd = tprev_rd;
                tnext_wa = tprev_rd;
                tnext_wd = tnext_rd;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (cmd.op) inside
            OP_EMIT_ADD, OP_EMIT_FULL, OP_ADD_FIX, OP_EMIT_WOKEN, OP_EMIT_DONE:
                emit = 1'b1;
            default:
                emit = 1'b0;
        endcase
    end

    wowe_ram #(.WIDTH(4), .DEPTH(NODE_COUNT)) u_ntask (
        .clk (clk), .we (link_we), .waddr (scan_reg), .wdata (t4),
        .raddr (raddr_t), .rdata (ntask_rd)
    );
    wowe_ram #(.WIDTH(4), .DEPTH(NODE_COUNT)) u_nobj (
        .clk (clk), .we (link_we), .waddr (scan_reg), .wdata (o4),
        .raddr (raddr_o), .rdata (nobj_rd)
    );
    wowe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_onext (
        .clk (clk), .we (onext_we), .waddr (onext_wa), .wdata (onext_wd),
        .raddr (raddr_o), .rdata (onext_rd)
    );
    wowe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_oprev (
        .clk (clk), .we (oprev_we), .waddr (oprev_wa), .wdata (oprev_wd),
        .raddr (raddr_o), .rdata (oprev_rd)
    );
    wowe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_tnext (
        .clk (clk), .we (tnext_we), .waddr (tnext_wa), .wdata (tnext_wd),
        .raddr (raddr_t), .rdata (tnext_rd)
    );
    wowe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_tprev (
        .clk (clk), .we (tprev_we), .waddr (tprev_wa), .wdata (tprev_wd),
        .raddr (raddr_t), .rdata (tprev_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvalid_reg <= '0;
            tall_reg   <= '0;
            for (int i = 0; i < OBJECT_COUNT; i++)
            begin
                owait_reg[i] <= '0;
                ohead_reg[i] <= '0;
            end
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                twait_reg[i] <= '0;
                thead_reg[i] <= '0;
            end
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= emit;
            unique case (cmd.op)
                OP_LOAD:
                begin
                    item_reg  <= in_item;
                    scan_reg  <= '0;
                    count_reg <= {1'b0, in_item.wake_count};
                end
                OP_FIND_FREE:
                    if (nvalid_reg[scan_reg] && 32'(scan_reg) != NODE_COUNT - 1)
                        scan_reg <= scan_reg + 1'b1;
                OP_ADD_LINK:
                begin
                    nvalid_reg[scan_reg] <= 1'b1;
                    otail_reg <= oprev_rd;
                    ttail_reg <= tprev_rd;
                    if (owait_reg[oi] == '0)
                        ohead_reg[oi] <= scan_reg;
                    owait_reg[oi] <= owait_reg[oi] + 1'b1;
                    if (twait_reg[ti] == '0)
                        thead_reg[ti] <= scan_reg;
                    twait_reg[ti] <= twait_reg[ti] + 1'b1;
                    tall_reg[ti] <= item_reg.wait_all_mode;
                end
                OP_ADD_FIX:
                    result <= '{RK_ADD_DONE, 4'd0, 1'b0, 8'd0, 1'b1};
                OP_WAKE_PICK:
                begin
                    node_reg <= ohead_reg[oi];
                    if (!item_reg.wake_all)
                        count_reg <= count_reg - 1'b1;
                end
                OP_TASK_CHECK:
                    node_reg <= thead_reg[wt];
                OP_UNLINK:
                begin
                    task_reg <= ntask_rd;
                    owait_reg[uo] <= owait_reg[uo] - 1'b1;
                    twait_reg[ut] <= twait_reg[ut] - 1'b1;
                    if (ohead_reg[uo] == node_reg)
                        ohead_reg[uo] <= (onext_rd != node_reg) ? onext_rd : '0;
                    if (thead_reg[ut] == node_reg)
                        thead_reg[ut] <= (tnext_rd != node_reg) ? tnext_rd : '0;
                    nvalid_reg[node_reg] <= 1'b0;
                end
                OP_EMIT_ADD:
                    result <= '{RK_ADD_DONE, 4'd0, 1'b0, 8'd0, 1'b1};
                OP_EMIT_FULL:
                    result <= '{RK_ADD_DONE, 4'd0, 1'b1, 8'd0, 1'b1};
                OP_EMIT_WOKEN:
                    result <= '{RK_WOKEN, task_reg, 1'b0, 8'd0, 1'b0};
                OP_EMIT_DONE:
                    result <= '{RK_WAKE_DONE, 4'd0, 1'b0,
                                item_reg.wake_all ? 8'd0 : count_reg[7:0], 1'b1};
                default: ;
            endcase
        end
    end
endmodule

/* rtl/wowe_ctrl.sv */
module wowe_ctrl
    import wowe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       kind,
    input  wowe_stat_t stat,
    output wowe_cmd_t  cmd,
    output logic       busy
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_DISP   = 9'b0_0000_0010,
        S_FIND   = 9'b0_0000_0100,
        S_LINK   = 9'b0_0000_1000,
        S_PICK   = 9'b0_0001_0000,
        S_UNL1   = 9'b0_0010_0000,
        S_CHECK  = 9'b0_0100_0000,
        S_DRAIN  = 9'b0_1000_0000,
        S_FIX    = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic drain_reg, drain_next;

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_DISP;
                end
            S_DISP:
                if (kind == KIND_ADD)
                begin
                    if (stat.add_bad)
                    begin
                        cmd.op = OP_EMIT_ADD;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_FIND;
                end
                else
                    state_next = S_PICK;
            S_FIND:
                if (stat.find_done)
                begin
                    if (stat.pool_full)
                    begin
                        cmd.op = OP_EMIT_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op = OP_ADD_READ;
                        state_next = S_LINK;
                    end
                end
                else
                    cmd.op = OP_FIND_FREE;
            S_LINK:
            begin
                cmd.op = OP_ADD_LINK;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.op = OP_ADD_FIX;
                state_next = S_IDLE;
            end
            S_PICK:
                if (stat.wake_more)
                begin
                    cmd.op = OP_WAKE_PICK;
                    state_next = S_UNL1;
                end
                else
                begin
                    cmd.op = OP_EMIT_DONE;
                    state_next = S_IDLE;
                end
            S_UNL1:
            begin
                cmd.op = OP_UNLINK;
                state_next = S_CHECK;
            end
            S_CHECK:
                if (stat.task_wake)
                begin
                    cmd.op = OP_EMIT_WOKEN;
                    state_next = S_DRAIN;
                end
                else
                    state_next = S_PICK;
            S_DRAIN:
                if (drain_reg)
                begin
                    cmd.op = OP_UNLINK;
                    drain_next = 1'b0;
                end
                else if (stat.task_more)
                begin
                    cmd.op = OP_TASK_CHECK;
                    drain_next = 1'b1;
                end
                else
                    state_next = S_PICK;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not set busy");
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !drain_reg) else $error("drain flag stuck");
endmodule
